FILE: hw/rtl/nfa_pkg.sv
// Package: types, sizes and codes for the NFA string acceptor.
`timescale 1ns / 1ps
package nfa_pkg;

    localparam int NUM_STATES  = 32;
    localparam int NUM_SYMBOLS = 16;
    localparam int FROM_W      = 5;
    localparam int SYM_W       = 4;
    localparam int SET_W       = 32;
    localparam int SYM_IDX_W   = $clog2(NUM_SYMBOLS);
    localparam int CFG_IDX_W   = 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FEED  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

    typedef struct packed {
        logic              op;
        logic [FROM_W-1:0] from_state;
        logic [SYM_W-1:0]  symbol;
        logic [SET_W-1:0]  next_set;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic [SET_W-1:0] active_set;
        logic             dead;
        logic             accepted;
        logic             string_done;
    } t_out_word;

    typedef struct packed {
        logic              en;
        logic [FROM_W-1:0] state;
        logic [SYM_W-1:0]  symbol;
        logic [SET_W-1:0]  data;
    } t_tbl_wr;

    typedef struct packed {
        logic                  start;
        logic                  sym_ok;
        logic [SYM_W-1:0]      symbol;
        logic [NUM_STATES-1:0] cur_set;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/nfa_string_acceptor.sv
// Top level: NFA string acceptor with control FSM, config registers and output register.
// Table writes: accepted when idle, no result word.
// Fed symbols: the word walks the row of state cells one cell per cycle; the result is
//   registered and moves into the output register once that register is free.
// New input is taken only when idle; the next is taken while a result waits in the output register.
// Reset: synchronous active low; clears table, config, active set and output valid.
`timescale 1ns / 1ps
module nfa_string_acceptor
    import nfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SET_W-1:0]     i_cfg_data
);

    t_state                r_state, n_state;
    logic [FROM_W-1:0]     r_start_state;
    logic [SET_W-1:0]      r_accept_mask;
    logic [NUM_STATES-1:0] r_active;
    logic                  r_at_start;
    logic                  r_go;
    logic                  r_sym_ok;
    logic [SYM_W-1:0]      r_sym;
    logic [NUM_STATES-1:0] r_cur;
    logic                  r_last;
    logic [NUM_STATES-1:0] r_res;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic                  w_in_acc;
    logic                  w_feed;
    logic                  w_load_out;
    logic                  w_out_free;
    logic [NUM_STATES-1:0] w_start_set;
    logic [NUM_STATES-1:0] w_cur;
    logic                  w_tok;
    logic [SET_W-1:0]      w_acc;
    t_tbl_wr               w_wr;
    t_chain_ctl            w_ctl;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_feed     = w_in_acc && (i_in_data.op == OP_FEED);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_start_set = '0;
        if (32'(r_start_state) < NUM_STATES) begin
            w_start_set = NUM_STATES'(1) << r_start_state;
        end
        w_cur = r_at_start ? w_start_set : r_active;
    end

    always_comb begin
        w_wr.en     = w_in_acc && (i_in_data.op == OP_WRITE)
                      && (32'(i_in_data.from_state) < NUM_STATES)
                      && (32'(i_in_data.symbol) < NUM_SYMBOLS);
        w_wr.state  = i_in_data.from_state;
        w_wr.symbol = i_in_data.symbol;
        w_wr.data   = i_in_data.next_set;
        w_ctl.start   = r_go;
        w_ctl.sym_ok  = r_sym_ok;
        w_ctl.symbol  = r_sym;
        w_ctl.cur_set = r_cur;
    end

    nfa_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_ctl   (w_ctl),
        .o_tok   (w_tok),
        .o_acc   (w_acc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_feed) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_tok) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RUN:  o_in_ready = 1'b0;
            ST_DONE: w_load_out = w_out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start_state <= '0;
            r_accept_mask <= '0;
            r_active      <= '0;
            r_at_start    <= 1'b1;
            r_go          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= w_feed;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_STATE: r_start_state <= i_cfg_data[FROM_W-1:0];
                    CFG_ACCEPT_MASK: r_accept_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load_out) begin
                r_at_start <= r_last;
                r_active   <= r_res;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_feed) begin
            r_sym    <= i_in_data.symbol;
            r_sym_ok <= 32'(i_in_data.symbol) < NUM_SYMBOLS;
            r_cur    <= w_cur;
            r_last   <= i_in_data.last;
        end
        if ((r_state == ST_RUN) && w_tok) begin
            r_res <= w_acc[NUM_STATES-1:0];
        end
        if (w_load_out) begin
            r_out.active_set  <= SET_W'(r_res);
            r_out.dead        <= (r_res == '0);
            r_out.accepted    <= r_last && ((r_res & r_accept_mask[NUM_STATES-1:0]) != '0);
            r_out.string_done <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/nfa_cell.sv
// One state cell: holds that state's transition rows and ORs its row into the passing word.
`timescale 1ns / 1ps
module nfa_cell
    import nfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [SYM_W-1:0] i_wr_sym,
    input  logic [SET_W-1:0] i_wr_data,
    input  logic [SYM_W-1:0] i_sym,
    input  logic             i_active,
    input  logic             i_tok,
    input  logic [SET_W-1:0] i_acc,
    output logic             o_tok,
    output logic [SET_W-1:0] o_acc
);

    logic [SET_W-1:0] r_rows [NUM_SYMBOLS];
    logic             r_tok;
    logic [SET_W-1:0] r_acc;
    logic [SET_W-1:0] n_acc;

    always_comb begin
        n_acc = i_acc;
        if (i_tok && i_active) begin
            n_acc = i_acc | r_rows[i_sym[SYM_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                r_rows[k] <= '0;
            end
            r_tok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_rows[i_wr_sym[SYM_IDX_W-1:0]] <= i_wr_data;
            end
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

FILE: hw/rtl/nfa_chain.sv
// Row of state cells: routes table writes and carries the next-set word from cell to cell.
`timescale 1ns / 1ps
module nfa_chain
    import nfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tbl_wr          i_wr,
    input  t_chain_ctl       i_ctl,
    output logic             o_tok,
    output logic [SET_W-1:0] o_acc
);

    logic             w_tok [NUM_STATES+1];
    logic [SET_W-1:0] w_acc [NUM_STATES+1];

    assign w_tok[0] = i_ctl.start;
    assign w_acc[0] = '0;

    for (genvar k = 0; k < NUM_STATES; k++) begin : g_cell
        logic w_wr_en;
        assign w_wr_en = i_wr.en && (i_wr.state == FROM_W'(k));

        nfa_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wr_en),
            .i_wr_sym  (i_wr.symbol),
            .i_wr_data (i_wr.data),
            .i_sym     (i_ctl.symbol),
            .i_active  (i_ctl.cur_set[k] && i_ctl.sym_ok),
            .i_tok     (w_tok[k]),
            .i_acc     (w_acc[k]),
            .o_tok     (w_tok[k+1]),
            .o_acc     (w_acc[k+1])
        );
    end

    assign o_tok = w_tok[NUM_STATES];
    assign o_acc = w_acc[NUM_STATES];

endmodule

FILE: hw/rtl/nfa_checker.sv
// Port checker for the NFA string acceptor, bound to the top level.
`timescale 1ns / 1ps
module nfa_checker
    import nfa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      o_in_ready,
    input  logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_out_word o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word dropped or changed while stalled");

    a_dead_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.dead == (o_out_data.active_set == '0)))
        else $error("dead flag disagrees with active set");

    a_accept_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |-> o_out_data.string_done
                                               && !o_out_data.dead)
        else $error("acceptance reported off the last symbol or on empty set");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind nfa_string_acceptor nfa_checker u_nfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: test/tb_nfa_string_acceptor.sv
// Testbench for nfa_string_acceptor: directed and random strings against a bit-parallel NFA model.
`timescale 1ns / 1ps
module tb_nfa_string_acceptor;
    import nfa_pkg::*;

    localparam int SETTLE_CYCLES  = NUM_STATES + 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SET_ITEMS      = 150;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_word             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_START_STATE;
    logic [SET_W-1:0]     cfg_data = '0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int quiet_cycles = 0;
    int n_fail = 0;
    int n_writes = 0;
    int n_symbols = 0;
    int n_strings = 0;
    int n_accepts = 0;
    int n_settings = 0;

    // NFA model state
    logic [SET_W-1:0]  tbl_model [NUM_STATES][NUM_SYMBOLS];
    logic [SET_W-1:0]  act_model = 32'd1;
    logic              fresh_string = 1'b1;
    logic [FROM_W-1:0] start_model = '0;
    logic [SET_W-1:0]  accept_model = '0;
    t_out_word         awaited_sets [$];

    nfa_string_acceptor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic void step_nfa(input t_in_word w);
        logic [SET_W-1:0] cur;
        logic [SET_W-1:0] nxt;
        t_out_word        r;
        if (w.op == OP_WRITE) begin
            tbl_model[w.from_state][w.symbol] = w.next_set;
            return;
        end
        cur = fresh_string ? (32'd1 << start_model) : act_model;
        nxt = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            if (cur[s]) nxt |= tbl_model[s][w.symbol];
        end
        r.active_set  = nxt;
        r.dead        = (nxt == '0);
        r.accepted    = w.last && ((nxt & accept_model) != '0);
        r.string_done = w.last;
        awaited_sets.push_back(r);
        act_model    = nxt;
        fresh_string = w.last;
    endfunction

    function automatic void check_field(input string name, input logic [SET_W-1:0] want,
                                        input logic [SET_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_idx == CFG_START_STATE) start_model = cfg_data[FROM_W-1:0];
                else if (cfg_idx == CFG_ACCEPT_MASK) accept_model = cfg_data;
            end
            if (in_valid && in_ready) begin
                if (in_data.op == OP_WRITE) n_writes++;
                else n_symbols++;
                step_nfa(in_data);
            end
            if (out_valid && out_ready) begin
                if (awaited_sets.size() == 0) begin
                    $error("result word with nothing pending: %h", out_data);
                    n_fail++;
                end else begin
                    want = awaited_sets.pop_front();
                    check_field("active_set", want.active_set, out_data.active_set);
                    check_field("dead", SET_W'(want.dead), SET_W'(out_data.dead));
                    check_field("accepted", SET_W'(want.accepted), SET_W'(out_data.accepted));
                    check_field("string_done", SET_W'(want.string_done),
                                SET_W'(out_data.string_done));
                    if (want.string_done) n_strings++;
                    if (want.accepted) n_accepts++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL nfa_string_acceptor");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic t_in_word noise_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_word)-1:0];
    endfunction

    task automatic load_row(input logic [FROM_W-1:0] from, input logic [SYM_W-1:0] sym,
                            input logic [SET_W-1:0] mask);
        t_in_word w;
        w = noise_word();
        w.op         = OP_WRITE;
        w.from_state = from;
        w.symbol     = sym;
        w.next_set   = mask;
        send_word(w);
    endtask

    task automatic feed_symbol(input logic [SYM_W-1:0] sym, input logic last);
        t_in_word w;
        w = noise_word();
        w.op     = OP_FEED;
        w.symbol = sym;
        w.last   = last;
        send_word(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_sets.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [FROM_W-1:0] start, input logic [SET_W-1:0] acc);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_START_STATE;
        cfg_data <= {{(SET_W-FROM_W){1'b0}}, start};
        @(posedge clk);
        cfg_idx  <= CFG_ACCEPT_MASK;
        cfg_data <= acc;
        @(posedge clk);
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // mostly sparse targets kept near the start state so strings stay alive
    function automatic logic [SET_W-1:0] near_mask(input logic [FROM_W-1:0] base);
        logic [SET_W-1:0]  m;
        logic [FROM_W-1:0] pos;
        m = '0;
        case ($urandom_range(9))
            0: m = '0;
            1: m = '1;
            2: m = $urandom;
            default: begin
                for (int b = $urandom_range(3, 1); b > 0; b--) begin
                    pos = FROM_W'(base + $urandom_range(7));
                    m[pos] = 1'b1;
                end
            end
        endcase
        return m;
    endfunction

    task automatic run_random_set(input logic [FROM_W-1:0] start, input logic [SET_W-1:0] acc);
        logic [SYM_W-1:0] sym_base;
        t_in_word         w;
        int               len;
        int               sent;
        wait_idle();
        program_regs(start, acc);
        sym_base = SYM_W'($urandom_range(NUM_SYMBOLS - 1));
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 4; j++) begin
                load_row(FROM_W'(start + i), SYM_W'(sym_base + j), near_mask(start));
            end
        end
        sent = 0;
        while (sent < SET_ITEMS) begin
            len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0) begin
                    w = noise_word();
                    w.op = OP_WRITE;
                    if ($urandom_range(1) == 1) begin
                        w.from_state = FROM_W'(start + $urandom_range(7));
                        w.symbol     = SYM_W'(sym_base + $urandom_range(3));
                        w.next_set   = near_mask(start);
                    end
                    send_word(w);
                    sent++;
                end
                w = noise_word();
                w.op = OP_FEED;
                if ($urandom_range(9) != 0) w.symbol = SYM_W'(sym_base + $urandom_range(3));
                // a few strings get a stray or missing end marker
                if ($urandom_range(19) != 0) w.last = (k == len - 1);
                send_word(w);
                sent++;
            end
        end
    endtask

    task automatic test_table_directed();
        src_idle_pct = 32;
        snk_idle_pct = 87;
        wait_idle();
        feed_symbol(4'd0, 1'b1);
        load_row(5'd0, 4'd0, 32'hFFFF_FFFF);
        load_row(5'd31, 4'd15, 32'h8000_0001);
        load_row(5'd0, 4'd15, 32'h0000_0002);
        feed_symbol(4'd0, 1'b0);
        feed_symbol(4'd15, 1'b0);
        feed_symbol(4'd7, 1'b1);
        // table write in the middle of a string
        feed_symbol(4'd0, 1'b0);
        load_row(5'd31, 4'd15, 32'h0000_0000);
        feed_symbol(4'd15, 1'b1);
    endtask

    task automatic test_config_directed();
        wait_idle();
        program_regs(5'd31, 32'hFFFF_FFFF);
        feed_symbol(4'd15, 1'b1);
        load_row(5'd31, 4'd15, 32'h8000_0000);
        feed_symbol(4'd15, 1'b0);
        feed_symbol(4'd15, 1'b1);
        // dead string stays dead up to its end
        feed_symbol(4'd3, 1'b0);
        feed_symbol(4'd15, 1'b0);
        feed_symbol(4'd15, 1'b1);
        // new start state only applies to the next string
        feed_symbol(4'd0, 1'b0);
        wait_idle();
        program_regs(5'd0, 32'hFFFF_FFFF);
        feed_symbol(4'd15, 1'b1);
        feed_symbol(4'd0, 1'b1);
    endtask

    task automatic test_strings_slow_receiver();
        src_idle_pct = 32;
        snk_idle_pct = 87;
        run_random_set(5'd0, 32'hFFFF_FFFF);
        run_random_set(FROM_W'($urandom), $urandom);
    endtask

    task automatic test_strings_slow_sender();
        src_idle_pct = 87;
        snk_idle_pct = 32;
        run_random_set(5'd31, 32'h0000_0000);
        run_random_set(FROM_W'($urandom), $urandom);
    endtask

    task automatic test_strings_full_rate();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random_set(FROM_W'($urandom), 32'h5555_AAAA);
        run_random_set(FROM_W'($urandom), $urandom);
    endtask

    initial begin
        for (int s = 0; s < NUM_STATES; s++) begin
            for (int y = 0; y < NUM_SYMBOLS; y++) tbl_model[s][y] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_table_directed();
        test_config_directed();
        test_strings_slow_receiver();
        test_strings_slow_sender();
        test_strings_full_rate();
        wait_idle();
        $display("Checked %0d symbols and %0d table writes; %0d strings ended, %0d accepted",
                 n_symbols, n_writes, n_strings, n_accepts);
        $display("Register settings: %0d, over three sender/receiver pacing profiles",
                 n_settings);
        if (n_fail == 0) begin
            $display("PASS nfa_string_acceptor");
        end else begin
            $display("FAIL nfa_string_acceptor");
        end
        $finish;
    end

endmodule

FILE: nfa_string_acceptor.f
hw/rtl/nfa_pkg.sv
hw/rtl/nfa_cell.sv
hw/rtl/nfa_chain.sv
hw/rtl/nfa_string_acceptor.sv
hw/rtl/nfa_checker.sv
test/tb_nfa_string_acceptor.sv
